/* hdl/qrs_pkg.sv */
// Shared types and constants of the quadratic root solver.
// No dependencies; imported by the cell modules and the top level.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS      = 16;
    localparam int OUT_W          = 34;

    localparam logic [63:0] SAT_HI = (64'd1 << (OUT_W - 1)) - 64'd1;
    localparam logic [63:0] SAT_LO_MAG = 64'd1 << (OUT_W - 1);

    typedef enum logic [1:0] {
        KIND_NOT_QUAD = 2'd0,
        KIND_NO_REAL  = 2'd1,
        KIND_DOUBLE   = 2'd2,
        KIND_TWO      = 2'd3
    } t_kind;

endpackage

/* hdl/quadratic_root_solver.sv */
// Stages: capture, products, discriminant, the sqrt chain, numerators, the divider chain and the output register.
// Throughput: one request per cycle; every stage advances together whenever
// the output register is empty or its result is being taken.
// Reset: synchronous active-low i_rst_n clears all stage valid bits; data
// registers are not reset. No state is kept between requests.
// Top level of the quadratic root solver; uses qrs_pkg, qrs_sqrt_cell, qrs_div_cell.
`timescale 1ns / 1ps

module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // coef_a, coef_b, coef_c from bit 0 up, zero padded to bytes
    input  logic [((3*COEF_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // discriminant, root_minus, root_plus from bit 0 up, zero padded
    output logic [((3*qrs_pkg::OUT_W+7)/8)*8-1:0] m_axis_tdata,
    // root_kind
    output logic [1:0]                        m_axis_tuser
);
    import qrs_pkg::*;

    localparam int W        = COEF_WIDTH;
    localparam int OUT_TD_W = ((3*OUT_W+7)/8)*8;
    localparam int NUM_W    = W + 18;          // signed numerator -b*2^16 +/- root
    localparam int MAG_W    = W + 17;          // numerator / quotient magnitude
    localparam int DEN_W    = W + 1;           // |2a|
    localparam int D_W      = (2*W + 2 > 64) ? 64 : 2*W + 2;
    localparam int R_W      = D_W/2 + FRAC_BITS;
    localparam int SQ_SIDE_W = 2 + OUT_W + NUM_W + DEN_W;
    localparam int DV_SIDE_W = 2 + OUT_W + 2;

    // whole pipeline moves as one; hold while a result waits untaken
    logic w_adv;
    assign w_adv = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = w_adv;

    // stage 0: capture request
    logic                r0_valid;
    logic signed [W-1:0] r0_a, r0_b, r0_c;

    // stage 1: products
    logic                  r1_valid;
    logic signed [2*W-1:0] r1_bb, r1_ac;
    logic signed [W-1:0]   r1_a, r1_b;

    // stage 2: discriminant and classification
    logic signed [63:0]  w_bb64, w_ac64, w_d64;
    logic [NUM_W-1:0]    w_bext;
    t_kind               w_kind;
    logic                r2_valid;
    t_kind               r2_kind;
    logic [OUT_W-1:0]    r2_disc;
    logic [NUM_W-1:0]    r2_nb;
    logic [DEN_W-1:0]    r2_den;
    logic [D_W-1:0]      r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (w_adv) begin
            r0_valid <= s_axis_tvalid;
            r1_valid <= r0_valid;
            r2_valid <= r1_valid;
        end
    end

    assign w_bb64 = 64'(r1_bb);
    assign w_ac64 = 64'(r1_ac);
    assign w_d64  = w_bb64 - (w_ac64 <<< 2);
    assign w_bext = {{(NUM_W-W-FRAC_BITS){r1_b[W-1]}}, r1_b, {FRAC_BITS{1'b0}}};

    always_comb begin
        if (r1_a == '0) begin
            w_kind = KIND_NOT_QUAD;
        end else if (w_d64[63]) begin
            w_kind = KIND_NO_REAL;
        end else if (w_d64 == '0) begin
            w_kind = KIND_DOUBLE;
        end else begin
            w_kind = KIND_TWO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r0_a    <= s_axis_tdata[W-1:0];
            r0_b    <= s_axis_tdata[2*W-1:W];
            r0_c    <= s_axis_tdata[3*W-1:2*W];
            r1_bb   <= r0_b * r0_b;
            r1_ac   <= r0_a * r0_c;
            r1_a    <= r0_a;
            r1_b    <= r0_b;
            r2_kind <= w_kind;
            r2_disc <= (w_kind == KIND_NOT_QUAD) ? '0 : w_d64[OUT_W-1:0];
            r2_nb   <= -w_bext;
            r2_den  <= {r1_a, 1'b0};
            r2_d    <= w_d64[D_W-1:0];
        end
    end

    // square-root chain: one cell per root bit
    logic                 sq_valid [0:R_W];
    logic [D_W-1:0]       sq_d     [0:R_W];
    logic [R_W:0]         sq_rem   [0:R_W];
    logic [R_W-1:0]       sq_root  [0:R_W];
    logic [SQ_SIDE_W-1:0] sq_side  [0:R_W];

    assign sq_valid[0] = r2_valid;
    assign sq_d[0]     = r2_d;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_side[0]  = {r2_kind, r2_disc, r2_nb, r2_den};

    for (genvar k = 0; k < R_W; k++) begin : g_sqrt
        qrs_sqrt_cell #(
            .D_W    (D_W),
            .R_W    (R_W),
            .SIDE_W (SQ_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (sq_valid[k]),
            .i_d     (sq_d[k]),
            .i_rem   (sq_rem[k]),
            .i_root  (sq_root[k]),
            .i_side  (sq_side[k]),
            .o_valid (sq_valid[k+1]),
            .o_d     (sq_d[k+1]),
            .o_rem   (sq_rem[k+1]),
            .o_root  (sq_root[k+1]),
            .o_side  (sq_side[k+1])
        );
    end

    // stage 3: numerators, signs and magnitudes
    logic [1:0]              w3_kind;
    logic [OUT_W-1:0]        w3_disc;
    logic signed [NUM_W-1:0] w3_nb, w3_r, w3_num_m, w3_num_p;
    logic signed [DEN_W-1:0] w3_den;
    logic [NUM_W-1:0]        w3_mag_m, w3_mag_p, w3_den_mag;

    assign {w3_kind, w3_disc, w3_nb, w3_den} = sq_side[R_W];
    assign w3_r       = NUM_W'(sq_root[R_W]);
    assign w3_num_m   = w3_nb - w3_r;
    assign w3_num_p   = w3_nb + w3_r;
    assign w3_mag_m   = w3_num_m[NUM_W-1] ? -w3_num_m : w3_num_m;
    assign w3_mag_p   = w3_num_p[NUM_W-1] ? -w3_num_p : w3_num_p;
    assign w3_den_mag = w3_den[DEN_W-1] ? -NUM_W'(w3_den) : NUM_W'(w3_den);

    logic             r3_valid;
    logic [1:0]       r3_kind;
    logic [OUT_W-1:0] r3_disc;
    logic             r3_neg_m, r3_neg_p;
    logic [MAG_W-1:0] r3_mag_m, r3_mag_p;
    logic [DEN_W-1:0] r3_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_adv) begin
            r3_valid <= sq_valid[R_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_kind  <= w3_kind;
            r3_disc  <= w3_disc;
            r3_neg_m <= w3_num_m[NUM_W-1] ^ w3_den[DEN_W-1];
            r3_neg_p <= w3_num_p[NUM_W-1] ^ w3_den[DEN_W-1];
            r3_mag_m <= w3_mag_m[MAG_W-1:0];
            r3_mag_p <= w3_mag_p[MAG_W-1:0];
            r3_den   <= w3_den_mag[DEN_W-1:0];
        end
    end

    // divider chain: one cell per quotient bit, both roots side by side
    logic                 dv_valid [0:MAG_W];
    logic [MAG_W-1:0]     dv_nq_m  [0:MAG_W];
    logic [DEN_W-1:0]     dv_rem_m [0:MAG_W];
    logic [MAG_W-1:0]     dv_nq_p  [0:MAG_W];
    logic [DEN_W-1:0]     dv_rem_p [0:MAG_W];
    logic [DEN_W-1:0]     dv_den   [0:MAG_W];
    logic [DV_SIDE_W-1:0] dv_side  [0:MAG_W];

    assign dv_valid[0] = r3_valid;
    assign dv_nq_m[0]  = r3_mag_m;
    assign dv_rem_m[0] = '0;
    assign dv_nq_p[0]  = r3_mag_p;
    assign dv_rem_p[0] = '0;
    assign dv_den[0]   = r3_den;
    assign dv_side[0]  = {r3_kind, r3_disc, r3_neg_m, r3_neg_p};

    for (genvar k = 0; k < MAG_W; k++) begin : g_div
        qrs_div_cell #(
            .NQ_W   (MAG_W),
            .DEN_W  (DEN_W),
            .SIDE_W (DV_SIDE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (dv_valid[k]),
            .i_nq_m  (dv_nq_m[k]),
            .i_rem_m (dv_rem_m[k]),
            .i_nq_p  (dv_nq_p[k]),
            .i_rem_p (dv_rem_p[k]),
            .i_den   (dv_den[k]),
            .i_side  (dv_side[k]),
            .o_valid (dv_valid[k+1]),
            .o_nq_m  (dv_nq_m[k+1]),
            .o_rem_m (dv_rem_m[k+1]),
            .o_nq_p  (dv_nq_p[k+1]),
            .o_rem_p (dv_rem_p[k+1]),
            .o_den   (dv_den[k+1]),
            .o_side  (dv_side[k+1])
        );
    end

    // apply sign and clamp to the 34-bit signed range
    function automatic logic [OUT_W-1:0] f_sat(input logic neg, input logic [63:0] mag);
        logic [63:0] tmp;
        tmp = ~mag + 64'd1;
        if (!neg) begin
            return (mag > SAT_HI) ? SAT_HI[OUT_W-1:0] : mag[OUT_W-1:0];
        end
        return (mag > SAT_LO_MAG) ? SAT_LO_MAG[OUT_W-1:0] : tmp[OUT_W-1:0];
    endfunction

    t_kind            w4_kind;
    logic [1:0]       w4_kind_raw;
    logic [OUT_W-1:0] w4_disc;
    logic             w4_neg_m, w4_neg_p;
    logic             w4_roots;

    assign {w4_kind_raw, w4_disc, w4_neg_m, w4_neg_p} = dv_side[MAG_W];
    assign w4_kind  = t_kind'(w4_kind_raw);
    assign w4_roots = (w4_kind == KIND_DOUBLE) || (w4_kind == KIND_TWO);

    // output register
    logic             r_out_valid;
    t_kind            r_out_kind;
    logic [OUT_W-1:0] r_out_disc, r_out_m, r_out_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= dv_valid[MAG_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_kind <= w4_kind;
            r_out_disc <= w4_disc;
            r_out_m    <= w4_roots ? f_sat(w4_neg_m, 64'(dv_nq_m[MAG_W])) : '0;
            r_out_p    <= w4_roots ? f_sat(w4_neg_p, 64'(dv_nq_p[MAG_W])) : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = OUT_TD_W'({r_out_p, r_out_m, r_out_disc});

endmodule

/* hdl/qrs_sqrt_cell.sv */
// One cell of the square-root chain: resolves one root bit per cycle in which i_adv is high.
// Depends on qrs_pkg for shared constants.
`timescale 1ns / 1ps

module qrs_sqrt_cell #(
    parameter int D_W    = 34,
    parameter int R_W    = 33,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [D_W-1:0]    i_d,
    input  logic [R_W:0]      i_rem,
    input  logic [R_W-1:0]    i_root,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [D_W-1:0]    o_d,
    output logic [R_W:0]      o_rem,
    output logic [R_W-1:0]    o_root,
    output logic [SIDE_W-1:0] o_side
);
    import qrs_pkg::*;

    logic [R_W+2:0] w_shift;
    logic [R_W+2:0] w_trial;
    logic [R_W+2:0] w_diff;
    logic           w_ge;
    logic [D_W-1:0] n_d;
    logic [R_W:0]   n_rem;
    logic [R_W-1:0] n_root;

    logic              r_valid;
    logic [D_W-1:0]    r_d;
    logic [R_W:0]      r_rem;
    logic [R_W-1:0]    r_root;
    logic [SIDE_W-1:0] r_side;

    always_comb begin
        w_shift = {i_rem, i_d[D_W-1 -: 2]};
        w_trial = {1'b0, i_root, 2'b01};
        w_diff  = w_shift - w_trial;
        w_ge    = (w_shift >= w_trial);
        n_rem   = w_ge ? w_diff[R_W:0] : w_shift[R_W:0];
        n_root  = {i_root[R_W-2:0], w_ge};
        n_d     = {i_d[D_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_d    <= n_d;
            r_rem  <= n_rem;
            r_root <= n_root;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_rem   = r_rem;
    assign o_root  = r_root;
    assign o_side  = r_side;

endmodule

/* hdl/qrs_div_cell.sv */
// One cell of the divider chain: one quotient bit per cycle for both roots, in cycles with i_adv high.
// Depends on qrs_pkg for shared constants.
`timescale 1ns / 1ps

module qrs_div_cell #(
    parameter int NQ_W   = 33,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_valid,
    input  logic [NQ_W-1:0]   i_nq_m,
    input  logic [DEN_W-1:0]  i_rem_m,
    input  logic [NQ_W-1:0]   i_nq_p,
    input  logic [DEN_W-1:0]  i_rem_p,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NQ_W-1:0]   o_nq_m,
    output logic [DEN_W-1:0]  o_rem_m,
    output logic [NQ_W-1:0]   o_nq_p,
    output logic [DEN_W-1:0]  o_rem_p,
    output logic [DEN_W-1:0]  o_den,
    output logic [SIDE_W-1:0] o_side
);
    import qrs_pkg::*;

    // restoring step: bring down the next dividend bit, subtract if it fits
    function automatic logic [NQ_W+DEN_W-1:0] f_step(
        input logic [NQ_W-1:0]  nq,
        input logic [DEN_W-1:0] rem,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] shift;
        logic [DEN_W:0] diff;
        logic           ge;
        shift = {rem, nq[NQ_W-1]};
        diff  = shift - {1'b0, den};
        ge    = (shift >= {1'b0, den});
        return {nq[NQ_W-2:0], ge, (ge ? diff[DEN_W-1:0] : shift[DEN_W-1:0])};
    endfunction

    logic [NQ_W+DEN_W-1:0] w_m;
    logic [NQ_W+DEN_W-1:0] w_p;

    logic              r_valid;
    logic [NQ_W-1:0]   r_nq_m;
    logic [DEN_W-1:0]  r_rem_m;
    logic [NQ_W-1:0]   r_nq_p;
    logic [DEN_W-1:0]  r_rem_p;
    logic [DEN_W-1:0]  r_den;
    logic [SIDE_W-1:0] r_side;

    assign w_m = f_step(i_nq_m, i_rem_m, i_den);
    assign w_p = f_step(i_nq_p, i_rem_p, i_den);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_nq_m  <= w_m[NQ_W+DEN_W-1:DEN_W];
            r_rem_m <= w_m[DEN_W-1:0];
            r_nq_p  <= w_p[NQ_W+DEN_W-1:DEN_W];
            r_rem_p <= w_p[DEN_W-1:0];
            r_den   <= i_den;
            r_side  <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_nq_m  = r_nq_m;
    assign o_rem_m = r_rem_m;
    assign o_nq_p  = r_nq_p;
    assign o_rem_p = r_rem_p;
    assign o_den   = r_den;
    assign o_side  = r_side;

endmodule

/* tb/quadratic_root_solver_tb.sv */
// Testbench for quadratic_root_solver: directed table then random coefficient sets,
// each result checked against a typed expectation or an in-bench fixed-point root predictor.
// Depends on qrs_pkg and the quadratic_root_solver RTL.
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
    import qrs_pkg::*;

    localparam int CW       = 16;
    localparam int N_RANDOM = 430;
    localparam int HOLD_LEN = 400;

    typedef struct {
        t_kind       kind;
        logic [33:0] disc;
        logic [33:0] rminus;
        logic [33:0] rplus;
    } t_roots;

    typedef struct {
        logic signed [CW-1:0] a, b, c;
        bit                   typed;
        t_roots               want;
    } t_coef_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // coef_a, coef_b, coef_c from bit 0 up
    logic [47:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // discriminant, root_minus, root_plus from bit 0 up, zero padded
    logic [103:0] m_axis_tdata;
    // root_kind
    logic [1:0]   m_axis_tuser;

    t_roots pending_roots[$];
    int     fail_cnt = 0;
    bit     burst_mode = 1'b0;   // sender offers back to back, receiver holds off
    bit     no_idle = 1'b0;      // neither side idles
    bit     burst_held = 1'b0;
    bit     sender_done = 1'b0;

    quadratic_root_solver #(.COEF_WIDTH(CW)) u_top (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Saturate a Q.16 quotient to the 34-bit signed range; division truncates toward zero.
    function automatic logic [33:0] div_sat(longint num, longint den);
        longint q;
        q = num / den;
        if (q > 64'sd8589934591) q = 64'sd8589934591;
        if (q < -64'sd8589934592) q = -64'sd8589934592;
        return q[33:0];
    endfunction

    function automatic t_roots predict_roots(logic signed [CW-1:0] a, b, c);
        longint       d, nb, den;
        logic [127:0] v, r, t;
        t_roots       o;
        o = '{KIND_NOT_QUAD, '0, '0, '0};
        if (a == 0) return o;
        d = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
        o.disc = d[33:0];
        if (d < 0) begin
            o.kind = KIND_NO_REAL;
            return o;
        end
        nb  = -(longint'(b) * 65536);
        den = 2 * longint'(a);
        if (d == 0) begin
            o.kind   = KIND_DOUBLE;
            o.rminus = div_sat(nb, den);
            o.rplus  = o.rminus;
        end else begin
            // floor(sqrt(d * 2^32)), one root bit per pass
            v = 128'(d) << 32;
            r = '0;
            for (int i = 47; i >= 0; i--) begin
                t = r | (128'd1 << i);
                if (t * t <= v) r = t;
            end
            o.kind   = KIND_TWO;
            o.rminus = div_sat(nb - longint'(r[63:0]), den);
            o.rplus  = div_sat(nb + longint'(r[63:0]), den);
        end
        return o;
    endfunction

    function automatic int draw_gap();
        if (no_idle || burst_mode) return 0;
        return (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
    endfunction

    // Offer one request; hold tvalid high across back-to-back requests.
    task automatic send_coefs(t_coef_row row);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {row.c, row.b, row.a};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_roots.push_back(row.typed ? row.want : predict_roots(row.a, row.b, row.c));
    endtask

    function automatic logic signed [CW-1:0] rand_coef();
        int w;
        logic [CW-1:0] raw;
        w = $urandom_range(1, CW);
        raw = CW'($urandom);
        if (w < CW) raw = CW'($signed(raw << (CW - w)) >>> (CW - w));
        return raw;
    endfunction

    // Directed table: typed expectations only where the answer is obvious.
    t_coef_row dir_tab[$] = '{
        '{16'sd0,      16'sd5,      16'sd7,      1, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd0,     -16'sd32768,  16'sd32767,  1, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd1,      16'sd0,      16'sd1,      1, '{KIND_NO_REAL, -34'sd4, '0, '0}},
        '{16'sd1,      16'sd2,      16'sd1,      1, '{KIND_DOUBLE, '0, -34'sd65536,
                                                      -34'sd65536}},
        '{16'sd1,      16'sd0,     -16'sd1,      1, '{KIND_TWO, 34'sd4, -34'sd65536,
                                                      34'sd65536}},
        '{16'sd1,      16'sd0,      16'sd0,      0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{-16'sd32768, -16'sd32768, 16'sd32767,  0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd32767,  16'sd32767,  16'sd32767,  0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd32767, -16'sd32768, -16'sd32768,  0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{-16'sd32768, 16'sd32767,  16'sd32767,  0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd1,     -16'sd32768, -16'sd32768,  0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{-16'sd1,     16'sd32767,  16'sd32767,  0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd1,      16'sd32767,  16'sd0,      0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd1,     -16'sd32768,  16'sd0,      0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{-16'sd1,    -16'sd2,     -16'sd1,      0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd3,      16'sd7,      16'sd2,      0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{-16'sd7,     16'sd3,      16'sd11,     0, '{KIND_NOT_QUAD, '0, '0, '0}},
        '{16'sd2,      16'sd3,      16'sd5,      0, '{KIND_NOT_QUAD, '0, '0, '0}}
    };

    // Sender: directed rows, then random sets with a burst, a drain pause and a span with no idling.
    initial begin
        t_coef_row row;
        int        k, mode;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_tab[i]) send_coefs(dir_tab[i]);
        for (int n = 0; n < N_RANDOM; n++) begin
            burst_mode = (n >= 120 && n < 260);
            no_idle    = (n >= 330 && n < 380);
            if (n == 300) begin
                // pause until the pipeline drains completely
                s_axis_tvalid <= 1'b0;
                wait (pending_roots.size() == 0);
                @(posedge i_clk);
            end
            row.typed = 1'b0;
            mode = $urandom_range(0, 7);
            row.a = rand_coef();
            row.b = rand_coef();
            row.c = rand_coef();
            if (mode == 0) begin
                row.a = '0;
            end else if (mode <= 2) begin
                // perfect square: a*(x+k)^2 gives a double root
                row.a = $urandom_range(1, 60) * ($urandom_range(0, 1) ? 1 : -1);
                k = $urandom_range(0, 22) - 11;
                row.b = 2 * row.a * k;
                row.c = row.a * k * k;
            end
            if (mode != 0 && row.a == 0) row.a = 1;
            send_coefs(row);
        end
        s_axis_tvalid <= 1'b0;
        burst_mode = 1'b0;
        sender_done = 1'b1;
    end

    // Receiver: random stalls per result, one long hold-off during the burst.
    initial begin
        t_roots      want;
        int          stall;
        logic [33:0] got_disc, got_rm, got_rp;
        // hold off until the block is out of reset and its valid bits are known
        wait (i_rst_n === 1'b1);
        forever begin
            if (burst_mode && !burst_held) begin
                burst_held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge i_clk);
            end else begin
                stall = no_idle ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12));
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got_disc = m_axis_tdata[33:0];
            got_rm   = m_axis_tdata[67:34];
            got_rp   = m_axis_tdata[101:68];
            if (pending_roots.size() == 0) begin
                $display("%0t: unexpected result kind=%0d disc=%h", $time, m_axis_tuser, got_disc);
                fail_cnt++;
            end else begin
                want = pending_roots.pop_front();
                if (m_axis_tuser != want.kind) begin
                    $display("%0t: root_kind expected %0d got %0d", $time, want.kind, m_axis_tuser);
                    fail_cnt++;
                end
                if (got_disc != want.disc) begin
                    $display("%0t: discriminant expected %h got %h", $time, want.disc, got_disc);
                    fail_cnt++;
                end
                if (got_rm != want.rminus) begin
                    $display("%0t: root_minus expected %h got %h", $time, want.rminus, got_rm);
                    fail_cnt++;
                end
                if (got_rp != want.rplus) begin
                    $display("%0t: root_plus expected %h got %h", $time, want.rplus, got_rp);
                    fail_cnt++;
                end
            end
        end
    end

    // Wrap up once every request has returned and the pipeline has gone quiet.
    initial begin
        wait (sender_done);
        wait (pending_roots.size() == 0);
        repeat (150) @(posedge i_clk);
        if (fail_cnt == 0 && pending_roots.size() == 0) begin
            $display("quadratic_root_solver verification clean");
        end else begin
            $display("quadratic_root_solver verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("quadratic_root_solver verification failed");
        $finish;
    end

endmodule

/* sim.f */
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver.sv
tb/quadratic_root_solver_tb.sv
